/* rtl/wfs_pkg.sv */
// Shared types, constants and register map of the wall-following steering block.
package wfs_pkg;

    // Controller constants.
    localparam int MAX_SAMPLES        = 4096;
    localparam int SAFETY_DISTANCE_MM = 1000;
    localparam int FORWARD_SPEED_MMPS = 400;
    localparam int TURN_RATE_MRADPS   = 250;

    // Depth of the result queue at the output.
    localparam int OUT_DEPTH = 16;

    localparam logic [11:0] COUNT_MAX =
        12'((MAX_SAMPLES - 1 < 4095) ? MAX_SAMPLES - 1 : 4095);

    localparam logic [16:0] SAFE_NEAR_MM = 17'(SAFETY_DISTANCE_MM);
    localparam logic [16:0] SAFE_FAR_MM  = 17'(2 * SAFETY_DISTANCE_MM);

    localparam logic [8:0] SPEED_FULL =
        9'((FORWARD_SPEED_MMPS > 511) ? 511 : FORWARD_SPEED_MMPS);
    localparam logic [8:0] SPEED_QUARTER =
        9'((FORWARD_SPEED_MMPS / 4 > 511) ? 511 : FORWARD_SPEED_MMPS / 4);
    localparam logic signed [15:0] TURN_RATE = 16'(TURN_RATE_MRADPS);

    // The divide by 256000 is a shift by 11 and a divide by 125.
    localparam int RATE_SHIFT   = 11;
    localparam int RATE_ODD_DIV = 125;
    localparam int RECIP_SHIFT  = 30;
    localparam logic [23:0] RECIP_ODD =
        24'(((64'd1 << RECIP_SHIFT) + RATE_ODD_DIV - 1) / RATE_ODD_DIV);
    localparam logic signed [35:0] SAT_SPAN = 36'(32768 * RATE_ODD_DIV);
    localparam logic signed [10:0] PD_SCALE = 11'sd1000;

    localparam logic signed [15:0] RATE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] RATE_MIN = 16'sh8000;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_LENGTH   = 3'd0,
        REG_ANGLE_MIN     = 3'd1,
        REG_ANGLE_STEP    = 3'd2,
        REG_TARGET_DIST   = 3'd3,
        REG_TARGET_ANGLE  = 3'd4,
        REG_GAIN_P        = 3'd5,
        REG_GAIN_D        = 3'd6,
        REG_GAIN_ANGLE    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [12:0]        scan_length;
        logic signed [22:0] angle_min_urad;
        logic [15:0]        angle_step_urad;
        logic [15:0]        target_distance_mm;
        logic signed [22:0] target_angle_urad;
        logic [15:0]        gain_p;
        logic [15:0]        gain_d;
        logic [15:0]        gain_angle;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        scan_length:        13'd640,
        angle_min_urad:     -23'sd521000,
        angle_step_urad:    16'd1637,
        target_distance_mm: 16'd1500,
        target_angle_urad:  -23'sd480000,
        gain_p:             16'd77,
        gain_d:             16'd64,
        gain_angle:         16'd102
    };

    typedef struct packed {
        logic [15:0] range_mm;
        logic        invalid;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [8:0]         linear_speed_mmps;
        logic signed [15:0] angular_rate_mradps;
    } t_out_word;

    // Errors of one finished scan, handed from the scan tracker to the control law.
    typedef struct packed {
        logic               valid;
        logic signed [16:0] dist_err;
        logic signed [17:0] dist_delta;
        logic [11:0]        near_idx;
        logic               turn;
        logic [8:0]         speed;
    } t_err_word;

endpackage

/* rtl/wfs_scan.sv */
// Per-sample scan tracking: nearest point, front distance and error terms.
module wfs_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  wfs_pkg::t_in_word  i_in_word,
    input  wfs_pkg::t_cfg      i_cfg,
    output wfs_pkg::t_err_word o_err
);
    import wfs_pkg::*;

    logic               r_in_valid;
    t_in_word           r_in;
    logic [11:0]        r_count, n_count;
    logic [15:0]        r_near_range, n_near_range;
    logic [11:0]        r_near_idx, n_near_idx;
    logic               r_near_found, n_near_found;
    logic [15:0]        r_front, n_front;
    logic signed [16:0] r_prev_err, n_prev_err;
    t_err_word          r_err, n_err;

    logic [11:0]        half;
    logic signed [16:0] dist_err;
    logic signed [17:0] dist_delta;

    assign half = i_cfg.scan_length[12:1];

    always_comb begin
        n_count      = r_count;
        n_near_range = r_near_range;
        n_near_idx   = r_near_idx;
        n_near_found = r_near_found;
        n_front      = r_front;
        n_prev_err   = r_prev_err;

        if (r_in_valid) begin
            if (r_count < half) begin
                if (!r_in.invalid) begin
                    if (!r_near_found) begin
                        n_near_found = 1'b1;
                        n_near_range = r_in.range_mm;
                        n_near_idx   = r_count;
                    end else if (r_in.range_mm != 16'd0 && r_in.range_mm < r_near_range) begin
                        n_near_range = r_in.range_mm;
                        n_near_idx   = r_count;
                    end
                end
            end else if (r_count == half) begin
                if (!r_in.invalid) begin
                    n_front = r_in.range_mm;
                end
                if (!r_near_found) begin
                    n_near_idx = half;
                    if (!r_in.invalid) begin
                        n_near_range = r_in.range_mm;
                    end
                end
            end

            if (r_in.last) begin
                n_count      = '0;
                n_near_found = 1'b0;
            end else if (r_count < COUNT_MAX) begin
                n_count = r_count + 12'd1;
            end
        end

        dist_err   = $signed({1'b0, n_near_range}) - $signed({1'b0, i_cfg.target_distance_mm});
        dist_delta = $signed({dist_err[16], dist_err}) - $signed({r_prev_err[16], r_prev_err});

        if (r_in_valid && r_in.last) begin
            n_prev_err = dist_err;
        end

        n_err.valid      = r_in_valid && r_in.last;
        n_err.dist_err   = dist_err;
        n_err.dist_delta = dist_delta;
        n_err.near_idx   = n_near_idx;
        n_err.turn       = {1'b0, n_front} < SAFE_NEAR_MM;
        if ({1'b0, n_front} < SAFE_NEAR_MM) begin
            n_err.speed = '0;
        end else if ({1'b0, n_front} < SAFE_FAR_MM) begin
            n_err.speed = SPEED_QUARTER;
        end else begin
            n_err.speed = SPEED_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_in_word;
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_count      <= '0;
            r_near_range <= '0;
            r_near_idx   <= '0;
            r_near_found <= 1'b0;
            r_front      <= '0;
            r_prev_err   <= '0;
            r_err        <= '0;
        end else begin
            r_in_valid   <= i_in_valid;
            r_count      <= n_count;
            r_near_range <= n_near_range;
            r_near_idx   <= n_near_idx;
            r_near_found <= n_near_found;
            r_front      <= n_front;
            r_prev_err   <= n_prev_err;
            r_err        <= n_err;
        end
    end

    assign o_err = r_err;

endmodule

/* rtl/wfs_law.sv */
// Pipelined PD steering law: products, sums, scaling and saturation.
module wfs_law (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wfs_pkg::t_err_word i_err,
    input  wfs_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    output wfs_pkg::t_out_word o_word
);
    import wfs_pkg::*;

    // Stage 2: first products.
    logic               r_v2, r_turn2;
    logic [8:0]         r_speed2;
    logic [27:0]        r_idx_prod2;
    logic signed [32:0] r_p_term2;
    logic signed [33:0] r_d_term2;
    // Stage 3: bearing error and distance sum.
    logic               r_v3, r_turn3;
    logic [8:0]         r_speed3;
    logic signed [29:0] r_ae3;
    logic signed [34:0] r_pd3;
    // Stage 4: scaled terms.
    logic               r_v4, r_turn4;
    logic [8:0]         r_speed4;
    logic signed [45:0] r_a4, r_b4;
    // Stage 5: total.
    logic               r_v5, r_turn5;
    logic [8:0]         r_speed5;
    logic signed [46:0] r_t5;
    // Stage 6: saturation flags and offset dividend.
    logic               r_v6, r_turn6, r_hi6, r_lo6;
    logic [8:0]         r_speed6;
    logic [22:0]        r_off6;

    logic signed [33:0] p_full;
    logic signed [35:0] d_full;
    logic signed [29:0] ae;
    logic signed [46:0] a_full;
    logic signed [45:0] b_full;
    logic signed [35:0] t_shift;
    logic [23:0]        off_sum;
    logic [46:0]        quot_prod;
    logic [15:0]        quot;

    assign p_full = i_err.dist_err * $signed({1'b0, i_cfg.gain_p});
    assign d_full = i_err.dist_delta * $signed({1'b0, i_cfg.gain_d});

    assign ae = $signed({{7{i_cfg.angle_min_urad[22]}}, i_cfg.angle_min_urad})
              + $signed({2'b00, r_idx_prod2})
              - $signed({{7{i_cfg.target_angle_urad[22]}}, i_cfg.target_angle_urad});

    assign a_full = r_ae3 * $signed({1'b0, i_cfg.gain_angle});
    assign b_full = $signed({{11{r_pd3[34]}}, r_pd3}) * PD_SCALE;

    // Arithmetic shift gives the floor of the divide by 2048.
    assign t_shift = r_t5[46:RATE_SHIFT];
    assign off_sum = t_shift[23:0] + SAT_SPAN[23:0];

    // Floor divide of the offset value by 125 through a scaled reciprocal;
    // removing the offset is a flip of the top bit.
    assign quot_prod = {24'd0, r_off6} * {23'd0, RECIP_ODD};
    assign quot      = quot_prod[RECIP_SHIFT+15:RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        r_turn2     <= i_err.turn;
        r_speed2    <= i_err.speed;
        r_idx_prod2 <= {16'd0, i_err.near_idx} * {12'd0, i_cfg.angle_step_urad};
        r_p_term2   <= p_full[32:0];
        r_d_term2   <= d_full[33:0];

        r_turn3  <= r_turn2;
        r_speed3 <= r_speed2;
        r_ae3    <= ae;
        r_pd3    <= $signed({{2{r_p_term2[32]}}, r_p_term2})
                  + $signed({r_d_term2[33], r_d_term2});

        r_turn4  <= r_turn3;
        r_speed4 <= r_speed3;
        r_a4     <= a_full[45:0];
        r_b4     <= b_full;

        r_turn5  <= r_turn4;
        r_speed5 <= r_speed4;
        r_t5     <= $signed({r_a4[45], r_a4}) - $signed({r_b4[45], r_b4});

        r_turn6  <= r_turn5;
        r_speed6 <= r_speed5;
        r_hi6    <= t_shift >= SAT_SPAN;
        r_lo6    <= t_shift < -SAT_SPAN;
        r_off6   <= off_sum[22:0];

        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v2 <= i_err.valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_comb begin
        o_word.linear_speed_mmps = r_speed6;
        if (r_turn6) begin
            o_word.angular_rate_mradps = TURN_RATE;
        end else if (r_hi6) begin
            o_word.angular_rate_mradps = RATE_MAX;
        end else if (r_lo6) begin
            o_word.angular_rate_mradps = RATE_MIN;
        end else begin
            o_word.angular_rate_mradps = $signed({~quot[15], quot[14:0]});
        end
    end

    assign o_valid = r_v6;

endmodule

/* rtl/wfs_fifo.sv */
// Result queue between the control law and the output channel.
module wfs_fifo #(
    parameter int DEPTH = wfs_pkg::OUT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  wfs_pkg::t_out_word i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output wfs_pkg::t_out_word o_word
);
    import wfs_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_out_word       r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            rd;

    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rd];
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (rd) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_count <= r_count + CW'(i_wr) - CW'(rd);
        end
    end

endmodule

/* rtl/wall_follow_pd_steering.sv */
// Top level of the wall-following PD steering controller.
//
//  Channel   Direction  Handshake                   Word
//  in        input      i_in_valid / o_in_ready     t_in_word: range_mm, invalid, last
//  out       output     o_out_valid / i_out_ready   t_out_word: speed, turn rate
//  cfg       input      i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// One range word is taken every clock cycle while o_in_ready is high. The steering
// word for a scan passes the input and error registers of the scan tracker, then
// the products, sums, scaling and saturation stages of the control law.
// Finished words wait in a queue of OUT_DEPTH entries; o_in_ready drops only while
// OUT_DEPTH steering words are queued or in flight. The synchronous reset restores
// the default register values and clears the scan state at once.
module wall_follow_pd_steering #(
    parameter int OUT_DEPTH = wfs_pkg::OUT_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  wfs_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output wfs_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [wfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wfs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import wfs_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    t_cfg          r_cfg;
    logic [CW-1:0] r_pending;
    logic          in_acc;
    logic          out_acc;
    logic          law_valid;
    t_out_word     law_word;
    t_err_word     err_word;

    // Every word marked last reserves a queue slot when it is accepted, so the
    // pipeline itself never has to stall.
    assign o_in_ready = r_pending < CW'(OUT_DEPTH);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + CW'(in_acc && i_in_word.last) - CW'(out_acc);
        end
    end

    // Register file. The user must write only while idle; the block won't check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SCAN_LENGTH:  r_cfg.scan_length        <= i_cfg_data[12:0];
                REG_ANGLE_MIN:    r_cfg.angle_min_urad     <= i_cfg_data[22:0];
                REG_ANGLE_STEP:   r_cfg.angle_step_urad    <= i_cfg_data[15:0];
                REG_TARGET_DIST:  r_cfg.target_distance_mm <= i_cfg_data[15:0];
                REG_TARGET_ANGLE: r_cfg.target_angle_urad  <= i_cfg_data[22:0];
                REG_GAIN_P:       r_cfg.gain_p             <= i_cfg_data[15:0];
                REG_GAIN_D:       r_cfg.gain_d             <= i_cfg_data[15:0];
                REG_GAIN_ANGLE:   r_cfg.gain_angle         <= i_cfg_data[15:0];
                default:          r_cfg                    <= r_cfg;
            endcase
        end
    end

    // Nearest point and front distance over the scan; error terms at its end.
    wfs_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_acc),
        .i_in_word  (i_in_word),
        .i_cfg      (r_cfg),
        .o_err      (err_word)
    );

    // Steering law: gains, scaling by 1/256000 with floor, saturation, turn select.
    wfs_law u_law (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_err   (err_word),
        .i_cfg   (r_cfg),
        .o_valid (law_valid),
        .o_word  (law_word)
    );

    // Output queue decouples the pipeline from a stalled consumer.
    wfs_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (law_valid),
        .i_word  (law_word),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule
